[rtl/core/sds_pkg.sv]
// Shared types and constants of the SD SPI-mode command sequencer.
// No dependencies; the step logic, the top level and the testbench refer to it by scoped names.
package sds_pkg;

	// operation codes of the request channel
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_XFER  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_READY_TO = 2'd0;
	localparam logic [1:0] CFG_TOKEN_TO = 2'd1;
	localparam logic [1:0] CFG_TRIES    = 2'd2;

	// sequencer phases
	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_DISCARD = 4'd1;
	localparam logic [3:0] PH_READY   = 4'd2;
	localparam logic [3:0] PH_FRAME   = 4'd3;
	localparam logic [3:0] PH_STUFF   = 4'd4;
	localparam logic [3:0] PH_RESP    = 4'd5;
	localparam logic [3:0] PH_TOKEN   = 4'd6;
	localparam logic [3:0] PH_DATA    = 4'd7;
	localparam logic [3:0] PH_CRC     = 4'd8;
	localparam logic [3:0] PH_RELEASE = 4'd9;

	// completion status
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BUSY_TO   = 3'd1;
	localparam logic [2:0] ST_NO_RESP   = 3'd2;
	localparam logic [2:0] ST_APP_REJ   = 3'd3;
	localparam logic [2:0] ST_BAD_TOKEN = 3'd4;

	// bytes and command numbers on the wire
	localparam logic [7:0] BYTE_IDLE   = 8'hFF;
	localparam logic [7:0] BYTE_TOKEN  = 8'hFE;
	localparam logic [7:0] BYTE_START  = 8'h40;
	localparam logic [7:0] CRC_CMD0    = 8'h95;
	localparam logic [7:0] CRC_CMD8    = 8'h87;
	localparam logic [7:0] CRC_DUMMY   = 8'h01;
	localparam logic [5:0] CMD_GO_IDLE = 6'd0;
	localparam logic [5:0] CMD_IF_COND = 6'd8;
	localparam logic [5:0] CMD_STOP    = 6'd12;
	localparam logic [5:0] CMD_APP     = 6'd55;
	localparam logic [9:0] FRAME_LEN   = 10'd6;
	localparam logic [9:0] CRC_LEN     = 10'd2;

	localparam logic [7:0] READY_TO_RST = 8'd50;
	localparam logic [7:0] TOKEN_TO_RST = 8'd10;
	localparam logic [4:0] TRIES_RST    = 5'd16;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  cmd_index;
		logic        is_app_cmd;
		logic [31:0] cmd_arg;
		logic [9:0]  read_length;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       chip_select;
		logic [7:0] data_byte;
		logic       data_valid;
		logic       data_last;
		logic       done_res;
		logic [2:0] status;
		logic [7:0] response;
	} result_t;

	typedef struct packed {
		logic [7:0] ready_to;
		logic [7:0] token_to;
		logic [4:0] tries;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [9:0]  byte_count;
		logic [7:0]  tick_cnt;
		logic [4:0]  tries_left;
		logic [5:0]  cmd;
		logic [31:0] arg;
		logic [9:0]  length;
		logic        app_pending;
		logic [7:0]  last_resp;
		logic [2:0]  end_code;
	} seq_state_t;

endpackage

[rtl/core/sds_req_if.sv]
// Request channel of the SD SPI sequencer: start, byte-done and tick items.
// Depends on nothing; payload members follow the item layout of sds_pkg.
interface sds_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [5:0]  cmd_index;
	logic        is_app_cmd;
	logic [31:0] cmd_arg;
	logic [9:0]  read_length;
	logic [7:0]  rx_byte;

	modport source (
		output valid, operation, cmd_index, is_app_cmd, cmd_arg, read_length, rx_byte,
		input  ready
	);
	modport sink (
		input  valid, operation, cmd_index, is_app_cmd, cmd_arg, read_length, rx_byte,
		output ready
	);
endinterface

[rtl/core/sds_res_if.sv]
// Result channel of the SD SPI sequencer: byte requests, block data and done.
// Depends on nothing; payload members follow the result layout of sds_pkg.
interface sds_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       tx_valid;
	logic       chip_select;
	logic [7:0] data_byte;
	logic       data_valid;
	logic       data_last;
	logic       done_res;
	logic [2:0] status;
	logic [7:0] response;

	modport source (
		output valid, tx_byte, tx_valid, chip_select, data_byte, data_valid, data_last,
		output done_res, status, response,
		input  ready
	);
	modport sink (
		input  valid, tx_byte, tx_valid, chip_select, data_byte, data_valid, data_last,
		input  done_res, status, response,
		output ready
	);
endinterface

[rtl/core/sds_step.sv]
// Next-state and result logic of the SD SPI sequencer for one item.
// Depends on sds_pkg; purely combinational, registers live in the top level.
module sds_step #(
	parameter int MAX_BLOCK_BYTES = 512
) (
	input  sds_pkg::seq_state_t st,
	input  sds_pkg::item_t      item,
	input  sds_pkg::cfg_t       cfg,
	output sds_pkg::seq_state_t nxt,
	output sds_pkg::result_t    res,
	output logic                has_res
);
	localparam logic [9:0] LEN_CAP = (MAX_BLOCK_BYTES < 1023) ? 10'(MAX_BLOCK_BYTES) : 10'd1023;

	logic [5:0]  cur_cmd;
	logic [31:0] cur_arg;
	logic [9:0]  bc_inc;
	logic [7:0]  rx;

	assign cur_cmd = st.app_pending ? sds_pkg::CMD_APP : st.cmd;
	assign cur_arg = st.app_pending ? 32'd0 : st.arg;
	assign bc_inc  = st.byte_count + 10'd1;
	assign rx      = item.rx_byte;

	// frame byte k of six: start+index, argument MSB first, then CRC
	function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [5:0] c,
			input logic [31:0] a);
		logic [7:0] b;
		case (k)
			3'd0: b = sds_pkg::BYTE_START | {2'b00, c};
			3'd1: b = a[31:24];
			3'd2: b = a[23:16];
			3'd3: b = a[15:8];
			3'd4: b = a[7:0];
			default: begin
				if (c == sds_pkg::CMD_GO_IDLE)      b = sds_pkg::CRC_CMD0;
				else if (c == sds_pkg::CMD_IF_COND) b = sds_pkg::CRC_CMD8;
				else                                b = sds_pkg::CRC_DUMMY;
			end
		endcase
		return b;
	endfunction

	always_comb begin
		nxt     = st;
		res     = '0;
		has_res = 1'b0;
		case (item.operation)
			sds_pkg::OP_TICK: begin
				if (st.tick_cnt != 8'd0) nxt.tick_cnt = st.tick_cnt - 8'd1;
			end
			sds_pkg::OP_START: begin
				if (st.phase == sds_pkg::PH_IDLE) begin
					nxt.cmd         = item.cmd_index;
					nxt.app_pending = item.is_app_cmd;
					nxt.arg         = item.cmd_arg;
					nxt.length      = (item.read_length > LEN_CAP) ? LEN_CAP : item.read_length;
					nxt.last_resp   = sds_pkg::BYTE_IDLE;
					nxt.end_code    = sds_pkg::ST_OK;
					nxt.byte_count  = 10'd0;
					nxt.phase       = sds_pkg::PH_DISCARD;
					nxt.tick_cnt    = cfg.ready_to;
					has_res         = 1'b1;
					res.tx_byte     = sds_pkg::BYTE_IDLE;
					res.tx_valid    = 1'b1;
					res.chip_select = 1'b1;
				end
			end
			sds_pkg::OP_XFER: begin
				// most branches request one more idle byte with the card selected
				has_res         = 1'b1;
				res.tx_byte     = sds_pkg::BYTE_IDLE;
				res.tx_valid    = 1'b1;
				res.chip_select = 1'b1;
				case (st.phase)
					sds_pkg::PH_DISCARD: nxt.phase = sds_pkg::PH_READY;
					sds_pkg::PH_READY: begin
						if (rx == sds_pkg::BYTE_IDLE) begin
							nxt.phase      = sds_pkg::PH_FRAME;
							nxt.byte_count = 10'd0;
							res.tx_byte    = frame_byte(3'd0, cur_cmd, cur_arg);
						end else if (st.tick_cnt == 8'd0) begin
							nxt.end_code    = sds_pkg::ST_BUSY_TO;
							nxt.phase       = sds_pkg::PH_RELEASE;
							res.chip_select = 1'b0;
						end
					end
					sds_pkg::PH_FRAME: begin
						nxt.byte_count = bc_inc;
						if (bc_inc < sds_pkg::FRAME_LEN) begin
							res.tx_byte = frame_byte(bc_inc[2:0], cur_cmd, cur_arg);
						end else if (cur_cmd == sds_pkg::CMD_STOP) begin
							nxt.phase = sds_pkg::PH_STUFF;
						end else begin
							nxt.phase      = sds_pkg::PH_RESP;
							nxt.tries_left = cfg.tries;
						end
					end
					sds_pkg::PH_STUFF: begin
						nxt.phase      = sds_pkg::PH_RESP;
						nxt.tries_left = cfg.tries;
					end
					sds_pkg::PH_RESP: begin
						if (!rx[7]) begin
							nxt.last_resp = rx;
							if (st.app_pending) begin
								nxt.app_pending = 1'b0;
								if (rx > 8'd1) begin
									nxt.end_code    = sds_pkg::ST_APP_REJ;
									nxt.phase       = sds_pkg::PH_RELEASE;
									res.chip_select = 1'b0;
								end else begin
									nxt.phase    = sds_pkg::PH_DISCARD;
									nxt.tick_cnt = cfg.ready_to;
								end
							end else if (st.length != 10'd0 && rx == 8'd0) begin
								nxt.phase    = sds_pkg::PH_TOKEN;
								nxt.tick_cnt = cfg.token_to;
							end else begin
								nxt.end_code    = sds_pkg::ST_OK;
								nxt.phase       = sds_pkg::PH_RELEASE;
								res.chip_select = 1'b0;
							end
						end else if (st.tries_left <= 5'd1) begin
							nxt.last_resp   = rx;
							nxt.end_code    = sds_pkg::ST_NO_RESP;
							nxt.phase       = sds_pkg::PH_RELEASE;
							res.chip_select = 1'b0;
						end else begin
							nxt.tries_left = st.tries_left - 5'd1;
						end
					end
					sds_pkg::PH_TOKEN: begin
						if (rx == sds_pkg::BYTE_IDLE && st.tick_cnt != 8'd0) begin
							nxt.phase = sds_pkg::PH_TOKEN;
						end else if (rx == sds_pkg::BYTE_TOKEN) begin
							nxt.phase      = sds_pkg::PH_DATA;
							nxt.byte_count = 10'd0;
						end else begin
							nxt.end_code    = sds_pkg::ST_BAD_TOKEN;
							nxt.phase       = sds_pkg::PH_RELEASE;
							res.chip_select = 1'b0;
						end
					end
					sds_pkg::PH_DATA: begin
						res.data_byte  = rx;
						res.data_valid = 1'b1;
						if (bc_inc >= st.length) begin
							res.data_last  = 1'b1;
							nxt.phase      = sds_pkg::PH_CRC;
							nxt.byte_count = 10'd0;
						end else begin
							nxt.byte_count = bc_inc;
						end
					end
					sds_pkg::PH_CRC: begin
						nxt.byte_count = bc_inc;
						if (bc_inc >= sds_pkg::CRC_LEN) begin
							nxt.end_code    = sds_pkg::ST_OK;
							nxt.phase       = sds_pkg::PH_RELEASE;
							res.chip_select = 1'b0;
						end
					end
					sds_pkg::PH_RELEASE: begin
						nxt.phase       = sds_pkg::PH_IDLE;
						res.tx_byte     = 8'd0;
						res.tx_valid    = 1'b0;
						res.chip_select = 1'b0;
						res.done_res    = 1'b1;
						res.status      = st.end_code;
					end
					default: begin
						// idle or an unused phase code: byte done is dropped
						has_res         = 1'b0;
						res.tx_byte     = 8'd0;
						res.tx_valid    = 1'b0;
						res.chip_select = 1'b0;
					end
				endcase
			end
			default: ;
		endcase
		res.response = nxt.last_resp;
	end
endmodule

[rtl/core/sd_spi_command_sequencer.sv]
// SD SPI-mode command sequencer: an accepted request goes into the input register, and its
// result is then loaded into the result register. Throughput one request per cycle, set by the
// single-pass step logic between the two registers; the only stall is a held result.
// Ticks, ignored starts and stray byte-done items leave no result.
// arst_n clears the phase to idle, all counters and the result valid; the timeout
// and retry registers return to 50, 10 and 16 ticks/tries.
module sd_spi_command_sequencer #(
	parameter int MAX_BLOCK_BYTES = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	sds_req_if.sink          req,
	sds_res_if.source        res,
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data
);
	// configuration registers
	sds_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ready_to <= sds_pkg::READY_TO_RST;
			cfg_q.token_to <= sds_pkg::TOKEN_TO_RST;
			cfg_q.tries    <= sds_pkg::TRIES_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sds_pkg::CFG_READY_TO: cfg_q.ready_to <= cfg_data;
				sds_pkg::CFG_TOKEN_TO: cfg_q.token_to <= cfg_data;
				sds_pkg::CFG_TRIES:    cfg_q.tries    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// input register stage
	logic          valid_s1;
	sds_pkg::item_t item_s1;
	logic          advance;

	// result register
	logic             out_valid_q;
	sds_pkg::result_t out_q;

	// protocol state
	sds_pkg::seq_state_t st_q;
	sds_pkg::seq_state_t st_nxt;
	sds_pkg::result_t    step_res;
	logic                step_has;

	// stage 1 moves on when the result register is empty or drains this cycle
	assign advance   = valid_s1 && (!out_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.operation   <= req.operation;
			item_s1.cmd_index   <= req.cmd_index;
			item_s1.is_app_cmd  <= req.is_app_cmd;
			item_s1.cmd_arg     <= req.cmd_arg;
			item_s1.read_length <= req.read_length;
			item_s1.rx_byte     <= req.rx_byte;
		end
	end

	sds_step #(
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) u_step (
		.st     (st_q),
		.item   (item_s1),
		.cfg    (cfg_q),
		.nxt    (st_nxt),
		.res    (step_res),
		.has_res(step_has)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase       <= sds_pkg::PH_IDLE;
			st_q.byte_count  <= '0;
			st_q.tick_cnt    <= '0;
			st_q.tries_left  <= '0;
			st_q.cmd         <= '0;
			st_q.arg         <= '0;
			st_q.length      <= '0;
			st_q.app_pending <= 1'b0;
			st_q.last_resp   <= sds_pkg::BYTE_IDLE;
			st_q.end_code    <= sds_pkg::ST_OK;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && step_has) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_has) out_q <= step_res;
	end

	assign res.valid       = out_valid_q;
	assign res.tx_byte     = out_q.tx_byte;
	assign res.tx_valid    = out_q.tx_valid;
	assign res.chip_select = out_q.chip_select;
	assign res.data_byte   = out_q.data_byte;
	assign res.data_valid  = out_q.data_valid;
	assign res.data_last   = out_q.data_last;
	assign res.done_res    = out_q.done_res;
	assign res.status      = out_q.status;
	assign res.response    = out_q.response;

	// a done transfer never requests another byte
	a_done_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.done_res |-> !out_q.tx_valid)
		else $error("done result requests a byte");

	// block data only arrives with the card selected
	a_data_selected: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.data_valid |-> out_q.chip_select && out_q.tx_valid)
		else $error("data byte without chip select");

	// error status is only reported on the done transfer
	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.done_res |-> out_q.status == sds_pkg::ST_OK)
		else $error("status outside done");

	// the step logic only produces defined phases
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase <= sds_pkg::PH_RELEASE)
		else $error("undefined phase");

	// a held result is not overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res.ready |-> !advance)
		else $error("result register overwritten");
endmodule

[test/sd_spi_command_sequencer_tb.sv]
// Self-checking testbench for the SD SPI-mode command sequencer.
// Uses sds_pkg and the sds_req_if / sds_res_if channels; emulates a card and
// checks every result against a cycle-free model of the command exchange.
module sd_spi_command_sequencer_tb;

	localparam int MAX_BLOCK_BYTES = 512;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int RANDOM_ITEMS    = 128;
	localparam int RANDOM_PHASES   = 8;

	// Command exchange model plus the queue of results it predicts.
	// note_request() steps the model on every accepted transfer;
	// check_reply() compares a delivered result with the oldest prediction.
	class cmd_exchange_checker;
		logic [7:0]       ready_to;
		logic [7:0]       token_to;
		logic [4:0]       tries;
		logic [3:0]       phase;
		logic [9:0]       nbytes;
		logic [9:0]       len;
		logic [7:0]       ticks;
		logic [7:0]       last_r1;
		logic [4:0]       tries_left;
		logic [5:0]       cmd;
		logic [31:0]      arg;
		logic             app_pending;
		logic [2:0]       end_code;
		sds_pkg::result_t due_replies[$];
		int               errors;

		function new();
			ready_to = sds_pkg::READY_TO_RST;
			token_to = sds_pkg::TOKEN_TO_RST;
			tries = sds_pkg::TRIES_RST;
			phase = sds_pkg::PH_IDLE;
			nbytes = '0;
			len = '0;
			ticks = '0;
			last_r1 = sds_pkg::BYTE_IDLE;
			tries_left = '0;
			cmd = '0;
			arg = '0;
			app_pending = 1'b0;
			end_code = sds_pkg::ST_OK;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
			sds_pkg::CFG_READY_TO: ready_to = val;
			sds_pkg::CFG_TOKEN_TO: token_to = val;
			sds_pkg::CFG_TRIES:    tries = val[4:0];
			default: ;
			endcase
		endfunction

		function sds_pkg::result_t reply(logic [7:0] tx, logic cs);
			sds_pkg::result_t r;
			r = '0;
			r.tx_byte = tx;
			r.tx_valid = 1'b1;
			r.chip_select = cs;
			r.response = last_r1;
			return r;
		endfunction

		// six-byte command frame; CMD55 with a zero argument while the prefix is pending
		function logic [7:0] frame_byte(logic [9:0] k);
			logic [5:0]  c;
			logic [31:0] a;
			c = app_pending ? sds_pkg::CMD_APP : cmd;
			a = app_pending ? 32'd0 : arg;
			case (k)
			10'd0: return sds_pkg::BYTE_START | {2'b00, c};
			10'd1: return a[31:24];
			10'd2: return a[23:16];
			10'd3: return a[15:8];
			10'd4: return a[7:0];
			default: begin
				if (c == sds_pkg::CMD_GO_IDLE) return sds_pkg::CRC_CMD0;
				if (c == sds_pkg::CMD_IF_COND) return sds_pkg::CRC_CMD8;
				return sds_pkg::CRC_DUMMY;
			end
			endcase
		endfunction

		function sds_pkg::result_t open_cmd();
			phase = sds_pkg::PH_DISCARD;
			ticks = ready_to;
			return reply(sds_pkg::BYTE_IDLE, 1'b1);
		endfunction

		// every ending deselects the card for one byte before done
		function sds_pkg::result_t close_seq(logic [2:0] code);
			end_code = code;
			phase = sds_pkg::PH_RELEASE;
			return reply(sds_pkg::BYTE_IDLE, 1'b0);
		endfunction

		function sds_pkg::result_t take_r1(logic [7:0] r1);
			last_r1 = r1;
			if (app_pending) begin
				app_pending = 1'b0;
				if (r1 > 8'd1) return close_seq(sds_pkg::ST_APP_REJ);
				return open_cmd();
			end
			if (len != 0 && r1 == 8'd0) begin
				phase = sds_pkg::PH_TOKEN;
				ticks = token_to;
				return reply(sds_pkg::BYTE_IDLE, 1'b1);
			end
			return close_seq(sds_pkg::ST_OK);
		endfunction

		function sds_pkg::result_t exchange(logic [7:0] rx);
			sds_pkg::result_t r;
			r = '0;
			case (phase)
			sds_pkg::PH_DISCARD: begin
				phase = sds_pkg::PH_READY;
				r = reply(sds_pkg::BYTE_IDLE, 1'b1);
			end
			sds_pkg::PH_READY: begin
				if (rx == sds_pkg::BYTE_IDLE) begin
					phase = sds_pkg::PH_FRAME;
					nbytes = '0;
					r = reply(frame_byte(10'd0), 1'b1);
				end else if (ticks == 0) begin
					r = close_seq(sds_pkg::ST_BUSY_TO);
				end else begin
					r = reply(sds_pkg::BYTE_IDLE, 1'b1);
				end
			end
			sds_pkg::PH_FRAME: begin
				nbytes = nbytes + 10'd1;
				if (nbytes < sds_pkg::FRAME_LEN) begin
					r = reply(frame_byte(nbytes), 1'b1);
				end else if (!app_pending && cmd == sds_pkg::CMD_STOP) begin
					phase = sds_pkg::PH_STUFF;
					r = reply(sds_pkg::BYTE_IDLE, 1'b1);
				end else begin
					phase = sds_pkg::PH_RESP;
					tries_left = tries;
					r = reply(sds_pkg::BYTE_IDLE, 1'b1);
				end
			end
			sds_pkg::PH_STUFF: begin
				phase = sds_pkg::PH_RESP;
				tries_left = tries;
				r = reply(sds_pkg::BYTE_IDLE, 1'b1);
			end
			sds_pkg::PH_RESP: begin
				if (!rx[7]) begin
					r = take_r1(rx);
				end else if (tries_left <= 5'd1) begin
					last_r1 = rx;
					r = close_seq(sds_pkg::ST_NO_RESP);
				end else begin
					tries_left = tries_left - 5'd1;
					r = reply(sds_pkg::BYTE_IDLE, 1'b1);
				end
			end
			sds_pkg::PH_TOKEN: begin
				if (rx == sds_pkg::BYTE_IDLE && ticks != 0) begin
					r = reply(sds_pkg::BYTE_IDLE, 1'b1);
				end else if (rx == sds_pkg::BYTE_TOKEN) begin
					phase = sds_pkg::PH_DATA;
					nbytes = '0;
					r = reply(sds_pkg::BYTE_IDLE, 1'b1);
				end else begin
					r = close_seq(sds_pkg::ST_BAD_TOKEN);
				end
			end
			sds_pkg::PH_DATA: begin
				nbytes = nbytes + 10'd1;
				r = reply(sds_pkg::BYTE_IDLE, 1'b1);
				r.data_byte = rx;
				r.data_valid = 1'b1;
				r.data_last = (nbytes >= len);
				if (r.data_last) begin
					phase = sds_pkg::PH_CRC;
					nbytes = '0;
				end
			end
			sds_pkg::PH_CRC: begin
				nbytes = nbytes + 10'd1;
				if (nbytes < sds_pkg::CRC_LEN) r = reply(sds_pkg::BYTE_IDLE, 1'b1);
				else r = close_seq(sds_pkg::ST_OK);
			end
			sds_pkg::PH_RELEASE: begin
				phase = sds_pkg::PH_IDLE;
				r.done_res = 1'b1;
				r.status = end_code;
				r.response = last_r1;
			end
			default: ;
			endcase
			return r;
		endfunction

		// returns 1 when the transfer is expected to produce a result
		function bit note_request(sds_pkg::item_t it);
			case (it.operation)
			sds_pkg::OP_TICK: begin
				if (ticks != 0) ticks = ticks - 8'd1;
				return 1'b0;
			end
			sds_pkg::OP_START: begin
				if (phase == sds_pkg::PH_IDLE) begin
					cmd = it.cmd_index;
					app_pending = it.is_app_cmd;
					arg = it.cmd_arg;
					len = (it.read_length > 10'(MAX_BLOCK_BYTES)) ?
						10'(MAX_BLOCK_BYTES) : it.read_length;
					last_r1 = sds_pkg::BYTE_IDLE;
					end_code = sds_pkg::ST_OK;
					nbytes = '0;
					due_replies.push_back(open_cmd());
					return 1'b1;
				end
			end
			sds_pkg::OP_XFER: begin
				if (phase != sds_pkg::PH_IDLE) begin
					due_replies.push_back(exchange(it.rx_byte));
					return 1'b1;
				end
			end
			default: ;
			endcase
			return 1'b0;
		endfunction

		function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(sds_pkg::result_t got);
			sds_pkg::result_t want;
			if (due_replies.size() == 0) begin
				$error("result with nothing expected: %p", got);
				errors++;
				return;
			end
			want = due_replies.pop_front();
			cmp_field("tx_byte", want.tx_byte, got.tx_byte);
			cmp_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
			cmp_field("chip_select", 8'(want.chip_select), 8'(got.chip_select));
			cmp_field("data_byte", want.data_byte, got.data_byte);
			cmp_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
			cmp_field("data_last", 8'(want.data_last), 8'(got.data_last));
			cmp_field("done_res", 8'(want.done_res), 8'(got.done_res));
			cmp_field("status", 8'(want.status), 8'(got.status));
			cmp_field("response", want.response, got.response);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	sds_req_if req ();
	sds_res_if res ();

	sd_spi_command_sequencer #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cmd_exchange_checker chk = new();

	// card emulation knobs; the directed part sets them per scenario
	bit         card_random = 1'b0;
	bit         ready_ok = 1'b1;     // card answers 0xFF while polled for ready
	bit         resp_ok = 1'b1;      // card answers the response poll at all
	logic [7:0] r1_app = 8'h01;      // R1 for the CMD55 prefix
	logic [7:0] r1_main = 8'h00;     // R1 for the command itself
	logic [7:0] token_byte = 8'hFE;  // 0xFF here means: never send a token
	bit         calm = 1'b0;         // no idling on either side while set
	int         answered = 0;        // transfers that caused a result
	int         stall_left = 0;
	int         stall_draw;
	int         cycles = 0;

	always #5 clk = ~clk;

	function automatic sds_pkg::item_t noise_item();
		logic [63:0]    bits;
		sds_pkg::item_t it;
		bits = {$urandom, $urandom};
		it = bits[58:0];
		return it;
	endfunction

	function automatic sds_pkg::item_t start_item(logic [5:0] c, logic app, logic [31:0] a,
			logic [9:0] n);
		sds_pkg::item_t it;
		it = noise_item();
		it.operation = sds_pkg::OP_START;
		it.cmd_index = c;
		it.is_app_cmd = app;
		it.cmd_arg = a;
		it.read_length = n;
		return it;
	endfunction

	function automatic sds_pkg::item_t random_start();
		logic [5:0] c;
		logic [9:0] n;
		int         roll;
		case ($urandom_range(0, 7))
		0: c = sds_pkg::CMD_GO_IDLE;
		1: c = sds_pkg::CMD_IF_COND;
		2: c = sds_pkg::CMD_STOP;
		3: c = sds_pkg::CMD_APP;
		default: c = 6'($urandom_range(0, 63));
		endcase
		roll = $urandom_range(0, 99);
		if (roll < 45) n = '0;
		else if (roll < 90) n = 10'($urandom_range(1, 16));
		else n = 10'($urandom_range(17, 80));
		return start_item(c, ($urandom_range(0, 9) < 3), $urandom, n);
	endfunction

	// Next transfer from the emulated card, chosen from where the sequencer stands.
	function automatic sds_pkg::item_t card_item();
		sds_pkg::item_t it;
		int             roll;
		it = noise_item();
		it.operation = sds_pkg::OP_XFER;
		roll = $urandom_range(0, 99);
		if (card_random) begin
			// some noise: stray starts, byte-dones while idle, the unused opcode
			if (roll < 6) begin
				it.operation = 2'($urandom_range(0, 3));
				return it;
			end
			// ticks, denser while a timeout is running
			if (roll < 14 || (roll < 35 && (chk.phase == sds_pkg::PH_READY ||
					chk.phase == sds_pkg::PH_TOKEN))) begin
				it.operation = sds_pkg::OP_TICK;
				return it;
			end
			roll = $urandom_range(0, 99);
			case (chk.phase)
			sds_pkg::PH_IDLE: return random_start();
			sds_pkg::PH_READY: begin
				if (roll < 60) it.rx_byte = sds_pkg::BYTE_IDLE;
			end
			sds_pkg::PH_RESP: begin
				if (roll < 35) it.rx_byte = 8'($urandom_range(128, 255));
				else if (roll < 80) it.rx_byte = 8'($urandom_range(0, 1));
				else it.rx_byte = 8'($urandom_range(0, 127));
			end
			sds_pkg::PH_TOKEN: begin
				if (roll < 45) it.rx_byte = sds_pkg::BYTE_IDLE;
				else if (roll < 85) it.rx_byte = sds_pkg::BYTE_TOKEN;
			end
			default: ;
			endcase
			return it;
		end
		// directed card: wait out timeouts with ticks, then answer as told
		case (chk.phase)
		sds_pkg::PH_READY: begin
			if (ready_ok) it.rx_byte = sds_pkg::BYTE_IDLE;
			else if (chk.ticks != 0) it.operation = sds_pkg::OP_TICK;
			else it.rx_byte = 8'h00;
		end
		sds_pkg::PH_RESP: begin
			if (!resp_ok) it.rx_byte = it.rx_byte | 8'h80;
			else it.rx_byte = chk.app_pending ? r1_app : r1_main;
		end
		sds_pkg::PH_TOKEN: begin
			if (token_byte != sds_pkg::BYTE_IDLE) it.rx_byte = token_byte;
			else if (chk.ticks != 0) it.operation = sds_pkg::OP_TICK;
			else it.rx_byte = sds_pkg::BYTE_IDLE;
		end
		default: ;
		endcase
		return it;
	endfunction

	// One request transfer: random gap, then hold valid until ready.
	// The model steps at the accepting edge, so the next choice sees fresh state.
	task automatic push(sds_pkg::item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= it.operation;
		req.cmd_index <= it.cmd_index;
		req.is_app_cmd <= it.is_app_cmd;
		req.cmd_arg <= it.cmd_arg;
		req.read_length <= it.read_length;
		req.rx_byte <= it.rx_byte;
		do @(posedge clk); while (req.ready !== 1'b1);
		if (chk.note_request(it)) answered++;
	endtask

	task automatic run_to_idle();
		while (chk.phase != sds_pkg::PH_IDLE) push(card_item());
	endtask

	task automatic play(sds_pkg::item_t start);
		push(start);
		run_to_idle();
	endtask

	task automatic card(bit rdy, bit rsp, logic [7:0] app_r1, logic [7:0] main_r1,
			logic [7:0] tok);
		card_random = 1'b0;
		ready_ok = rdy;
		resp_ok = rsp;
		r1_app = app_r1;
		r1_main = main_r1;
		token_byte = tok;
	endtask

	// stop sending, let every result drain, then cover the pipeline latency
	task automatic settle();
		req.valid <= 1'b0;
		while (chk.due_replies.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		chk.set_reg(idx, val);
	endtask

	task automatic set_regs(logic [7:0] rdy_to, logic [7:0] tok_to, logic [4:0] n_tries);
		write_reg(sds_pkg::CFG_READY_TO, rdy_to);
		write_reg(sds_pkg::CFG_TOKEN_TO, tok_to);
		write_reg(sds_pkg::CFG_TRIES, {3'b000, n_tries});
		cfg_wr_en <= 1'b0;
	endtask

	// Result side: after each transfer ready may drop for a randomly drawn stall, unless calm is set.
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_left <= 0;
		end else if (res.valid === 1'b1 && res.ready === 1'b1) begin
			stall_draw = calm ? 0 : $urandom_range(0, 4);
			res.ready <= (stall_draw == 0);
			stall_left <= stall_draw;
		end else if (res.ready !== 1'b1) begin
			if (stall_left <= 1) res.ready <= 1'b1;
			stall_left <= stall_left - 1;
		end
	end

	// result monitor; values sampled here are the ones before this edge
	always @(posedge clk) begin
		if (arst_n && res.valid === 1'b1 && res.ready === 1'b1)
			chk.check_reply({res.tx_byte, res.tx_valid, res.chip_select, res.data_byte,
				res.data_valid, res.data_last, res.done_res, res.status, res.response});
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int target;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= sds_pkg::CFG_READY_TO;
		cfg_data <= '0;
		req.valid <= 1'b0;
		req.operation <= sds_pkg::OP_TICK;
		req.cmd_index <= '0;
		req.is_app_cmd <= 1'b0;
		req.cmd_arg <= '0;
		req.read_length <= '0;
		req.rx_byte <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, reset register values ---
		// ignored while idle: a byte-done, the unused opcode, a tick
		begin
			sds_pkg::item_t it;
			it = noise_item();
			it.operation = sds_pkg::OP_XFER;
			push(it);
			it.operation = sds_pkg::OP_NONE;
			push(it);
			it.operation = sds_pkg::OP_TICK;
			push(it);
		end
		card(1, 1, 8'h01, 8'h01, sds_pkg::BYTE_TOKEN);
		play(start_item(sds_pkg::CMD_GO_IDLE, 1'b0, 32'h0, 10'd0));         // CRC 0x95
		play(start_item(sds_pkg::CMD_IF_COND, 1'b0, 32'h0000_01AA, 10'd0)); // CRC 0x87
		card(1, 1, 8'h01, 8'h00, sds_pkg::BYTE_TOKEN);
		play(start_item(sds_pkg::CMD_STOP, 1'b0, 32'h0, 10'd0));            // stuff byte
		play(start_item(6'd17, 1'b0, 32'hFFFF_FFFF, 10'd4));          // block read
		play(start_item(6'd17, 1'b0, 32'h0000_0200, 10'd1));          // one-byte block
		play(start_item(6'd41, 1'b1, 32'h4000_0000, 10'd0));          // ACMD, prefix ok
		play(start_item(6'd63, 1'b1, 32'h8000_0001, 10'd0));
		card(1, 1, 8'h02, 8'h00, sds_pkg::BYTE_TOKEN);
		play(start_item(6'd41, 1'b1, 32'h0, 10'd0));                  // prefix rejected
		card(1, 1, 8'h00, 8'h04, sds_pkg::BYTE_TOKEN);
		play(start_item(6'd17, 1'b0, 32'h1234_5678, 10'd8));          // R1 error, no data
		card(1, 1, 8'h00, 8'h00, 8'h00);
		play(start_item(6'd17, 1'b0, 32'h0, 10'd8));                  // wrong token
		card(1, 1, 8'h00, 8'h00, sds_pkg::BYTE_IDLE);
		play(start_item(6'd17, 1'b0, 32'h0, 10'd8));                  // token timeout
		card(1, 0, 8'h00, 8'h00, sds_pkg::BYTE_TOKEN);
		play(start_item(6'd9, 1'b0, 32'h0, 10'd0));                   // no response
		play(start_item(6'd41, 1'b1, 32'h0, 10'd0));                  // prefix: no response
		// a second start while busy is dropped
		card(1, 1, 8'h01, 8'h00, sds_pkg::BYTE_TOKEN);
		push(start_item(6'd17, 1'b0, $urandom, 10'd3));
		push(start_item(6'd24, 1'b1, $urandom, 10'd5));
		run_to_idle();
		// a length above the block size saturates
		play(start_item(6'd18, 1'b0, $urandom, 10'd1023));

		// zero registers: no ready wait, single response try, no token wait
		settle();
		set_regs(8'd0, 8'd0, 5'd0);
		card(0, 1, 8'h00, 8'h00, sds_pkg::BYTE_TOKEN);
		play(start_item(6'd17, 1'b0, 32'h0, 10'd4));                  // busy timeout
		play(start_item(6'd41, 1'b1, 32'h0, 10'd0));                  // prefix: busy timeout
		card(1, 0, 8'h00, 8'h00, sds_pkg::BYTE_TOKEN);
		play(start_item(6'd17, 1'b0, 32'h0, 10'd4));
		card(1, 1, 8'h00, 8'h00, sds_pkg::BYTE_IDLE);
		play(start_item(6'd17, 1'b0, 32'h0, 10'd4));

		// --- random part, one register setting per phase ---
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			case (p)
			0: set_regs(sds_pkg::READY_TO_RST, sds_pkg::TOKEN_TO_RST, sds_pkg::TRIES_RST);
			1: set_regs(8'd1, 8'd1, 5'd1);
			2: set_regs(8'd255, 8'd255, 5'd31);
			3: set_regs(8'd0, 8'd0, 5'd0);
			default: set_regs(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
				5'($urandom_range(1, 31)));
			endcase
			card_random = 1'b1;
			target = answered + RANDOM_ITEMS / RANDOM_PHASES;
			// finish the sequence in flight before the next register write
			while (answered < target || chk.phase != sds_pkg::PH_IDLE) begin
				if ($urandom_range(0, 39) == 0) calm = !calm;
				push(card_item());
			end
		end

		settle();
		if (chk.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
